/* hdl/inflight_request_tracker_unit_macros.svh */
// ----------------------------------------------------------------------------
// Inflight request tracker assertion macros
// Shared concurrent check forms, clocked on aclk and gated by reset.
// ----------------------------------------------------------------------------
`ifndef INFLIGHT_REQUEST_TRACKER_UNIT_MACROS_SVH
`define INFLIGHT_REQUEST_TRACKER_UNIT_MACROS_SVH

// same-cycle implication
`define IRT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication
`define IRT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

/* hdl/irt_pkg.sv */
// ----------------------------------------------------------------------------
// Inflight request tracker package
// Sizes, status and mode codes, and slot table types.
// ----------------------------------------------------------------------------
package irt_pkg;

    localparam int SLOTS     = 8;
    localparam int TARGETS   = 4;
    localparam int TIME_BITS = 48;
    localparam int GEN_BITS  = 32;
    localparam int TTL_BITS  = 32;
    localparam int TAG_BITS  = 32;
    localparam int SLOT_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PEND_BITS = $clog2(TARGETS + 1);

    localparam logic [TTL_BITS-1:0] TTL_RESET = TTL_BITS'(30000);
    localparam logic [GEN_BITS-1:0] GEN_FIRST = GEN_BITS'(1);

    localparam logic [1:0] MODE_ALLOC = 2'd0;
    localparam logic [1:0] MODE_ACK   = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    localparam logic [2:0] STAT_DONE        = 3'd0;
    localparam logic [2:0] STAT_INVALID     = 3'd1;
    localparam logic [2:0] STAT_FULL        = 3'd2;
    localparam logic [2:0] STAT_NONE_QUEUED = 3'd3;
    localparam logic [2:0] STAT_NO_MATCH    = 3'd4;

    typedef struct packed {
        logic                 used;
        logic [TIME_BITS-1:0] expiry;
        logic [GEN_BITS-1:0]  generation;
        logic [PEND_BITS-1:0] pending;
        logic                 emergency;
        logic [TAG_BITS-1:0]  event_tag;
    } irt_slot_t;

    typedef struct packed {
        logic [SLOT_BITS-1:0] idx;
        logic                 used_we;
        logic                 used;
        logic                 pend_we;
        logic [PEND_BITS-1:0] pending;
        logic                 stamp;
        logic [TIME_BITS-1:0] expiry;
        logic [GEN_BITS-1:0]  generation;
        logic                 emergency;
        logic [TAG_BITS-1:0]  event_tag;
    } irt_slot_wr_t;

endpackage

/* hdl/inflight_request_tracker_unit.sv */
// An invalid item goes straight to the finish state; acknowledge and tick scan every slot, and
// allocate scans every slot and then stamps the chosen one, before the result is registered.
// One slot is compared per cycle through the single scan read port, and the input is not
// ready until the result is handed off, so a new item is taken only after the last is done.
// Reset (aresetn low, synchronous) frees all slots, zeroes the generation counter,
// sets ttl_ms to 30000 and drops any pending result.
// ----------------------------------------------------------------------------
// Inflight request tracker
// Slot table of in-flight requests with allocate, acknowledge and expiry scan.
// ----------------------------------------------------------------------------
`include "inflight_request_tracker_unit_macros.svh"

module inflight_request_tracker_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [irt_pkg::TTL_BITS-1:0]    cfg_ttl_ms,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_mode,
    input  logic [irt_pkg::TIME_BITS-1:0]   s_now_ms,
    input  logic [2:0]                      s_queued_count,
    input  logic                            s_emergency,
    input  logic [irt_pkg::TAG_BITS-1:0]    s_event_tag,
    input  logic [irt_pkg::GEN_BITS-1:0]    s_ack_generation,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [2:0]                      m_status,
    output logic [irt_pkg::GEN_BITS-1:0]    m_generation,
    output logic                            m_completed,
    output logic                            m_emergency_out,
    output logic [irt_pkg::TAG_BITS-1:0]    m_event_tag_out
);
    import irt_pkg::*;

    localparam logic [1:0] FSM_IDLE   = 2'd0;
    localparam logic [1:0] FSM_SCAN   = 2'd1;
    localparam logic [1:0] FSM_STAMP  = 2'd2;
    localparam logic [1:0] FSM_FINISH = 2'd3;

    localparam logic [SLOT_BITS-1:0] LAST_IDX = SLOT_BITS'(SLOTS - 1);

    logic [1:0]           state_reg, state_next;
    logic [SLOT_BITS-1:0] idx_reg, idx_next;
    logic [1:0]           mode_reg, mode_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [2:0]           queued_reg, queued_next;
    logic                 emerg_reg, emerg_next;
    logic [TAG_BITS-1:0]  tag_reg, tag_next;
    logic [GEN_BITS-1:0]  ackgen_reg, ackgen_next;
    logic [TTL_BITS-1:0]  ttl_reg;
    logic [GEN_BITS-1:0]  gen_cnt_reg, gen_cnt_next;
    logic                 found_reg, found_next;
    logic [SLOT_BITS-1:0] free_idx_reg, free_idx_next;

    logic [2:0]           res_status_reg, res_status_next;
    logic [GEN_BITS-1:0]  res_gen_reg, res_gen_next;
    logic                 res_completed_reg, res_completed_next;
    logic                 res_emerg_reg, res_emerg_next;
    logic [TAG_BITS-1:0]  res_tag_reg, res_tag_next;

    logic                 m_valid_reg, m_valid_next;
    logic [2:0]           m_status_reg, m_status_next;
    logic [GEN_BITS-1:0]  m_gen_reg, m_gen_next;
    logic                 m_completed_reg, m_completed_next;
    logic                 m_emerg_reg, m_emerg_next;
    logic [TAG_BITS-1:0]  m_tag_reg, m_tag_next;

    irt_slot_t            slot;
    irt_slot_wr_t         tbl_wr;
    logic                 expired;
    logic                 gen_hit;
    logic                 in_ok;
    logic [GEN_BITS-1:0]  gen_inc;
    logic [2:0]           queued_sat;
    logic [TIME_BITS:0]   expiry_sum;

    irt_slot_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_idx  (idx_reg),
        .rd_slot (slot),
        .wr      (tbl_wr)
    );

    assign cfg_ready       = 1'b1;
    assign s_ready         = (state_reg == FSM_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_generation    = m_gen_reg;
    assign m_completed     = m_completed_reg;
    assign m_emergency_out = m_emerg_reg;
    assign m_event_tag_out = m_tag_reg;

    assign expired    = slot.used && (now_reg >= slot.expiry);
    assign gen_hit    = slot.used && (slot.generation == ackgen_reg) && (slot.pending != '0);
    assign gen_inc    = ((gen_cnt_reg + GEN_BITS'(1)) == '0) ? GEN_FIRST
                                                             : gen_cnt_reg + GEN_BITS'(1);
    assign queued_sat = (queued_reg > 3'(TARGETS)) ? 3'(TARGETS) : queued_reg;
    assign expiry_sum = {1'b0, now_reg} + (TIME_BITS + 1)'(ttl_reg);

    always_comb begin
        unique case (s_mode) inside
            MODE_ALLOC, MODE_TICK: in_ok = (s_now_ms != '0);
            MODE_ACK:              in_ok = (s_ack_generation != '0);
            default:               in_ok = 1'b0;
        endcase
    end

    always_comb begin
        state_next         = state_reg;
        idx_next           = idx_reg;
        mode_next          = mode_reg;
        now_next           = now_reg;
        queued_next        = queued_reg;
        emerg_next         = emerg_reg;
        tag_next           = tag_reg;
        ackgen_next        = ackgen_reg;
        gen_cnt_next       = gen_cnt_reg;
        found_next         = found_reg;
        free_idx_next      = free_idx_reg;
        res_status_next    = res_status_reg;
        res_gen_next       = res_gen_reg;
        res_completed_next = res_completed_reg;
        res_emerg_next     = res_emerg_reg;
        res_tag_next       = res_tag_reg;
        m_valid_next       = m_valid_reg && !m_ready;
        m_status_next      = m_status_reg;
        m_gen_next         = m_gen_reg;
        m_completed_next   = m_completed_reg;
        m_emerg_next       = m_emerg_reg;
        m_tag_next         = m_tag_reg;
        tbl_wr             = '0;

        unique case (state_reg)
            FSM_IDLE: begin
                if (s_valid) begin
                    mode_next          = s_mode;
                    now_next           = s_now_ms;
                    queued_next        = s_queued_count;
                    emerg_next         = s_emergency;
                    tag_next           = s_event_tag;
                    ackgen_next        = s_ack_generation;
                    idx_next           = '0;
                    found_next         = 1'b0;
                    free_idx_next      = '0;
                    res_status_next    = STAT_INVALID;
                    res_gen_next       = '0;
                    res_completed_next = 1'b0;
                    res_emerg_next     = 1'b0;
                    res_tag_next       = '0;
                    state_next         = in_ok ? FSM_SCAN : FSM_FINISH;
                end
            end
            FSM_SCAN: begin
                tbl_wr.idx = idx_reg;
                if (mode_reg == MODE_ACK) begin
                    if (gen_hit && !found_reg) begin
                        found_next         = 1'b1;
                        tbl_wr.pend_we     = 1'b1;
                        tbl_wr.pending     = slot.pending - PEND_BITS'(1);
                        res_status_next    = STAT_DONE;
                        res_gen_next       = ackgen_reg;
                        res_emerg_next     = slot.emergency;
                        res_tag_next       = slot.event_tag;
                        if (slot.pending == PEND_BITS'(1)) begin
                            tbl_wr.used_we     = 1'b1;
                            tbl_wr.used        = 1'b0;
                            res_completed_next = 1'b1;
                        end
                    end
                end else begin
                    if (expired) begin
                        tbl_wr.used_we = 1'b1;
                        tbl_wr.used    = 1'b0;
                    end
                    if (mode_reg == MODE_ALLOC && !found_reg && (!slot.used || expired)) begin
                        found_next    = 1'b1;
                        free_idx_next = idx_reg;
                    end
                end
                if (idx_reg == LAST_IDX) begin
                    if (mode_reg == MODE_ALLOC) begin
                        state_next = FSM_STAMP;
                    end else begin
                        state_next = FSM_FINISH;
                        if (mode_reg == MODE_TICK) begin
                            res_status_next = STAT_DONE;
                        end else if (!found_next) begin
                            res_status_next = STAT_NO_MATCH;
                        end
                    end
                end else begin
                    idx_next = idx_reg + SLOT_BITS'(1);
                end
            end
            FSM_STAMP: begin
                state_next = FSM_FINISH;
                if (!found_reg) begin
                    res_status_next = STAT_FULL;
                end else begin
                    gen_cnt_next = gen_inc;
                    if (queued_sat == 3'd0) begin
                        res_status_next = STAT_NONE_QUEUED;
                    end else begin
                        tbl_wr.idx        = free_idx_reg;
                        tbl_wr.used_we    = 1'b1;
                        tbl_wr.used       = 1'b1;
                        tbl_wr.pend_we    = 1'b1;
                        tbl_wr.pending    = PEND_BITS'(queued_sat);
                        tbl_wr.stamp      = 1'b1;
                        tbl_wr.expiry     = expiry_sum[TIME_BITS] ? '1
                                                                  : expiry_sum[TIME_BITS-1:0];
                        tbl_wr.generation = gen_inc;
                        tbl_wr.emergency  = emerg_reg;
                        tbl_wr.event_tag  = emerg_reg ? tag_reg : '0;
                        res_status_next   = STAT_DONE;
                        res_gen_next      = gen_inc;
                        res_emerg_next    = emerg_reg;
                        res_tag_next      = emerg_reg ? tag_reg : '0;
                    end
                end
            end
            FSM_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next     = 1'b1;
                    m_status_next    = res_status_reg;
                    m_gen_next       = res_gen_reg;
                    m_completed_next = res_completed_reg;
                    m_emerg_next     = res_emerg_reg;
                    m_tag_next       = res_tag_reg;
                    state_next       = FSM_IDLE;
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= FSM_IDLE;
            idx_reg     <= '0;
            found_reg   <= 1'b0;
            gen_cnt_reg <= '0;
            ttl_reg     <= TTL_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            found_reg   <= found_next;
            gen_cnt_reg <= gen_cnt_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                ttl_reg <= cfg_ttl_ms;
            end
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg          <= mode_next;
        now_reg           <= now_next;
        queued_reg        <= queued_next;
        emerg_reg         <= emerg_next;
        tag_reg           <= tag_next;
        ackgen_reg        <= ackgen_next;
        free_idx_reg      <= free_idx_next;
        res_status_reg    <= res_status_next;
        res_gen_reg       <= res_gen_next;
        res_completed_reg <= res_completed_next;
        res_emerg_reg     <= res_emerg_next;
        res_tag_reg       <= res_tag_next;
        m_status_reg      <= m_status_next;
        m_gen_reg         <= m_gen_next;
        m_completed_reg   <= m_completed_next;
        m_emerg_reg       <= m_emerg_next;
        m_tag_reg         <= m_tag_next;
    end

    `IRT_ASSERT_NOW(a_idx_stamp, state_reg == FSM_STAMP, idx_reg == LAST_IDX)
    `IRT_ASSERT_NOW(a_stamp_free, tbl_wr.stamp, found_reg && state_reg == FSM_STAMP)
    `IRT_ASSERT_NOW(a_completed_done, m_valid && m_completed, m_status == STAT_DONE)
    `IRT_ASSERT_NEXT(a_gen_nonzero, state_reg == FSM_STAMP && found_reg, gen_cnt_reg != '0)

endmodule

/* hdl/irt_slot_table.sv */
// ----------------------------------------------------------------------------
// Inflight request tracker slot table
// Slot registers with one scan read port and one write port.
// ----------------------------------------------------------------------------
module irt_slot_table (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [irt_pkg::SLOT_BITS-1:0]   rd_idx,
    output irt_pkg::irt_slot_t              rd_slot,
    input  irt_pkg::irt_slot_wr_t           wr
);
    import irt_pkg::*;

    logic                 used_reg      [SLOTS];
    logic [TIME_BITS-1:0] expiry_reg    [SLOTS];
    logic [GEN_BITS-1:0]  generation_reg[SLOTS];
    logic [PEND_BITS-1:0] pending_reg   [SLOTS];
    logic                 emergency_reg [SLOTS];
    logic [TAG_BITS-1:0]  event_tag_reg [SLOTS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                used_reg[i] <= 1'b0;
            end
        end else if (wr.used_we) begin
            used_reg[wr.idx] <= wr.used;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.pend_we) begin
            pending_reg[wr.idx] <= wr.pending;
        end
        if (wr.stamp) begin
            expiry_reg[wr.idx]     <= wr.expiry;
            generation_reg[wr.idx] <= wr.generation;
            emergency_reg[wr.idx]  <= wr.emergency;
            event_tag_reg[wr.idx]  <= wr.event_tag;
        end
    end

    always_comb begin
        rd_slot.used       = used_reg[rd_idx];
        rd_slot.expiry     = expiry_reg[rd_idx];
        rd_slot.generation = generation_reg[rd_idx];
        rd_slot.pending    = pending_reg[rd_idx];
        rd_slot.emergency  = emergency_reg[rd_idx];
        rd_slot.event_tag  = event_tag_reg[rd_idx];
    end

endmodule

/* tb/inflight_request_tracker_unit_tb.sv */
// ----------------------------------------------------------------------------
// Inflight request tracker testbench
// Drives allocate, acknowledge and tick requests through the slot table under
// several slot lifetimes. Each request is predicted against a local copy of
// the table and every reply is checked field by field, in order.
// ----------------------------------------------------------------------------
module inflight_request_tracker_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import irt_pkg::*;

    localparam logic [1:0]           MODE_SPARE   = 2'd3;
    localparam logic [TIME_BITS-1:0] TIME_MAX     = '1;
    localparam int                   IDLE_PCT     = 17;
    localparam int                   SETTLE_CYCLES = 2 * SLOTS + 8;
    localparam int                   STALL_LIMIT  = 2000;
    localparam int                   PRINT_LIMIT  = 40;

    typedef struct packed {
        logic [1:0]           mode;
        logic [TIME_BITS-1:0] now;
        logic [2:0]           queued;
        logic                 emerg;
        logic [TAG_BITS-1:0]  tag;
        logic [GEN_BITS-1:0]  ack_gen;
    } request_t;

    typedef struct packed {
        logic [2:0]          status;
        logic [GEN_BITS-1:0] gen;
        logic                completed;
        logic                urgent;
        logic [TAG_BITS-1:0] tag;
    } reply_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [TTL_BITS-1:0]  cfg_ttl_ms;
    logic                 s_valid;
    logic                 s_ready;
    logic [1:0]           s_mode;
    logic [TIME_BITS-1:0] s_now_ms;
    logic [2:0]           s_queued_count;
    logic                 s_emergency;
    logic [TAG_BITS-1:0]  s_event_tag;
    logic [GEN_BITS-1:0]  s_ack_generation;
    logic                 m_valid;
    logic                 m_ready;
    logic [2:0]           m_status;
    logic [GEN_BITS-1:0]  m_generation;
    logic                 m_completed;
    logic                 m_emergency_out;
    logic [TAG_BITS-1:0]  m_event_tag_out;

    // slot table mirror
    logic                 busy      [SLOTS];
    logic [TIME_BITS-1:0] deadline  [SLOTS];
    logic [GEN_BITS-1:0]  gen_of    [SLOTS];
    logic [2:0]           acks_left [SLOTS];
    logic                 urgent    [SLOTS];
    logic [TAG_BITS-1:0]  tag_of    [SLOTS];
    logic [GEN_BITS-1:0]  last_gen;
    logic [TTL_BITS-1:0]  lifetime_ms;

    reply_t               replies_due [$];
    logic [TIME_BITS-1:0] clock_ms;
    bit                   calm;
    int                   error_count;
    int                   items_sent;
    int                   replies_checked;
    int                   settings_used;
    int                   quiet_cycles;

    inflight_request_tracker_unit dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_ttl_ms       (cfg_ttl_ms),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mode           (s_mode),
        .s_now_ms         (s_now_ms),
        .s_queued_count   (s_queued_count),
        .s_emergency      (s_emergency),
        .s_event_tag      (s_event_tag),
        .s_ack_generation (s_ack_generation),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_generation     (m_generation),
        .m_completed      (m_completed),
        .m_emergency_out  (m_emergency_out),
        .m_event_tag_out  (m_event_tag_out)
    );

    always #1 aclk = ~aclk;

    function automatic void retire_due(input logic [TIME_BITS-1:0] now);
        for (int i = 0; i < SLOTS; i++) begin
            if (busy[i] && now >= deadline[i]) begin
                busy[i]      = 1'b0;
                acks_left[i] = '0;
            end
        end
    endfunction

    function automatic reply_t track_request(input request_t rq);
        reply_t             r;
        int                 pick;
        logic [2:0]         q;
        logic [TIME_BITS:0] sum;
        r        = '0;
        r.status = STAT_INVALID;
        pick     = -1;
        case (rq.mode)
            MODE_ALLOC: begin
                if (rq.now != '0) begin
                    retire_due(rq.now);
                    r.status = STAT_FULL;
                    for (int i = SLOTS - 1; i >= 0; i--) begin
                        if (!busy[i]) pick = i;
                    end
                    if (pick >= 0) begin
                        last_gen = last_gen + GEN_BITS'(1);
                        if (last_gen == '0) last_gen = GEN_FIRST;
                        q = (rq.queued > TARGETS) ? 3'(TARGETS) : rq.queued;
                        if (q == '0) begin
                            r.status = STAT_NONE_QUEUED;
                        end else begin
                            sum             = {1'b0, rq.now} + (TIME_BITS + 1)'(lifetime_ms);
                            busy[pick]      = 1'b1;
                            deadline[pick]  = sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
                            gen_of[pick]    = last_gen;
                            acks_left[pick] = q;
                            urgent[pick]    = rq.emerg;
                            tag_of[pick]    = rq.emerg ? rq.tag : '0;
                            r.status        = STAT_DONE;
                            r.gen           = last_gen;
                            r.urgent        = rq.emerg;
                            r.tag           = tag_of[pick];
                        end
                    end
                end
            end
            MODE_ACK: begin
                if (rq.ack_gen != '0) begin
                    r.status = STAT_NO_MATCH;
                    for (int i = 0; i < SLOTS && pick < 0; i++) begin
                        if (busy[i] && gen_of[i] == rq.ack_gen && acks_left[i] != '0) pick = i;
                    end
                    if (pick >= 0) begin
                        acks_left[pick] = acks_left[pick] - 3'd1;
                        r.status        = STAT_DONE;
                        r.gen           = rq.ack_gen;
                        r.urgent        = urgent[pick];
                        r.tag           = tag_of[pick];
                        if (acks_left[pick] == '0) begin
                            r.completed = 1'b1;
                            busy[pick]  = 1'b0;
                        end
                    end
                end
            end
            MODE_TICK: begin
                if (rq.now != '0) begin
                    retire_due(rq.now);
                    r.status = STAT_DONE;
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] want_v,
                                   input logic [63:0] got_v);
        if (error_count < PRINT_LIMIT)
            $display("MISMATCH reply %0d: %s expected 0x%0h got 0x%0h",
                     replies_checked, what, want_v, got_v);
        error_count++;
    endtask

    always @(negedge aclk) begin
        m_ready = calm ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin : reply_check
        reply_t want;
        if (aresetn && m_valid && m_ready) begin
            if (replies_due.size() == 0) begin
                report_mismatch("reply with nothing outstanding, status", '0, 64'(m_status));
            end else begin
                want = replies_due.pop_front();
                if (m_status !== want.status)
                    report_mismatch("status", 64'(want.status), 64'(m_status));
                if (m_generation !== want.gen)
                    report_mismatch("generation", 64'(want.gen), 64'(m_generation));
                if (m_completed !== want.completed)
                    report_mismatch("completed", 64'(want.completed), 64'(m_completed));
                if (m_emergency_out !== want.urgent)
                    report_mismatch("emergency_out", 64'(want.urgent), 64'(m_emergency_out));
                if (m_event_tag_out !== want.tag)
                    report_mismatch("event_tag_out", 64'(want.tag), 64'(m_event_tag_out));
            end
            replies_checked++;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic issue_request(input logic [1:0] mode, input logic [TIME_BITS-1:0] now,
                                 input logic [2:0] queued, input logic emerg,
                                 input logic [TAG_BITS-1:0] tag,
                                 input logic [GEN_BITS-1:0] ack_gen);
        request_t rq;
        rq = '{mode: mode, now: now, queued: queued, emerg: emerg, tag: tag, ack_gen: ack_gen};
        if (!calm && $urandom_range(0, 99) < IDLE_PCT)
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        s_mode           = rq.mode;
        s_now_ms         = rq.now;
        s_queued_count   = rq.queued;
        s_emergency      = rq.emerg;
        s_event_tag      = rq.tag;
        s_ack_generation = rq.ack_gen;
        s_valid          = 1'b1;
        do @(posedge aclk); while (!s_ready);
        replies_due.push_back(track_request(rq));
        items_sent++;
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic wait_tracker_idle();
        while (replies_due.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_lifetime(input logic [TTL_BITS-1:0] ms);
        wait_tracker_idle();
        cfg_ttl_ms = ms;
        cfg_valid  = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        lifetime_ms = ms;
        settings_used++;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic test_invalid_items();
        issue_request(MODE_ACK, TIME_MAX, 3'd7, 1'b1, '1, 32'd1);
        issue_request(MODE_SPARE, TIME_MAX, 3'd7, 1'b1, '1, '1);
        issue_request(MODE_ALLOC, '0, 3'd2, 1'b1, $urandom, $urandom);
        issue_request(MODE_TICK, '0, 3'd1, 1'b0, $urandom, $urandom);
        issue_request(MODE_ACK, TIME_BITS'($urandom), 3'd1, 1'b0, $urandom, '0);
    endtask

    task automatic test_allocate_and_ack();
        clock_ms = 48'd1000;
        issue_request(MODE_ALLOC, clock_ms, 3'd2, 1'b1, 32'hFFFF_FFFF, $urandom);
        issue_request(MODE_ALLOC, clock_ms, 3'd7, 1'b0, 32'hDEAD_BEEF, $urandom);
        issue_request(MODE_ALLOC, clock_ms, 3'd0, 1'b1, $urandom, $urandom);
        issue_request(MODE_ACK, TIME_BITS'($urandom), 3'd0, 1'b0, $urandom, 32'd1);
        issue_request(MODE_ACK, TIME_BITS'($urandom), 3'd0, 1'b0, $urandom, 32'd1);
        issue_request(MODE_ACK, TIME_BITS'($urandom), 3'd0, 1'b0, $urandom, 32'd2);
        issue_request(MODE_ACK, TIME_BITS'($urandom), 3'd0, 1'b0, $urandom, 32'hFFFF_FFFF);
    endtask

    task automatic test_table_full();
        clock_ms = 48'd2000;
        repeat (SLOTS) begin
            issue_request(MODE_ALLOC, clock_ms, 3'($urandom_range(1, 7)), 1'($urandom), $urandom,
                          $urandom);
        end
        clock_ms = clock_ms + TIME_BITS'(TTL_RESET);
        issue_request(MODE_TICK, clock_ms, 3'd0, 1'b0, $urandom, $urandom);
        issue_request(MODE_ALLOC, clock_ms, 3'd4, 1'b1, $urandom, $urandom);
    endtask

    task automatic test_lifetime_extremes();
        set_lifetime(32'hFFFF_FFFF);
        issue_request(MODE_ALLOC, TIME_MAX - TIME_BITS'(5), 3'd1, 1'b1, $urandom, $urandom);
        issue_request(MODE_TICK, TIME_MAX, 3'd0, 1'b0, $urandom, $urandom);
        set_lifetime(32'd0);
        issue_request(MODE_ALLOC, 48'd5000, 3'd2, 1'b0, $urandom, $urandom);
        issue_request(MODE_TICK, 48'd5000, 3'd0, 1'b0, $urandom, $urandom);
        set_lifetime(32'd1);
        issue_request(MODE_ALLOC, 48'd100, 3'd3, 1'b1, $urandom, $urandom);
        issue_request(MODE_TICK, 48'd100, 3'd0, 1'b0, $urandom, $urandom);
        issue_request(MODE_TICK, 48'd101, 3'd0, 1'b0, $urandom, $urandom);
    endtask

    task automatic test_random_traffic(input int count, input logic [TTL_BITS-1:0] ms,
                                       input logic [63:0] max_step, input bit quiet_start);
        logic [GEN_BITS-1:0] live_gens [SLOTS];
        int                  n_live;
        int                  sel;
        logic [63:0]         step;
        logic [63:0]         wide;
        logic [2:0]          q;
        logic [GEN_BITS-1:0] g;
        set_lifetime(ms);
        clock_ms = clock_ms + 48'h2_0000_0000;
        for (int k = 0; k < count; k++) begin
            calm = quiet_start && k < 80;
            sel  = $urandom_range(0, 99);
            step = {$urandom, $urandom} % (max_step + 1);
            wide = {$urandom, $urandom};
            clock_ms = clock_ms + step[TIME_BITS-1:0];
            if (sel < 50) begin
                q = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                                : 3'($urandom_range(1, TARGETS));
                issue_request(MODE_ALLOC, clock_ms, q, 1'($urandom), $urandom, $urandom);
            end else if (sel < 80) begin
                n_live = 0;
                for (int i = 0; i < SLOTS; i++) begin
                    if (busy[i]) begin
                        live_gens[n_live] = gen_of[i];
                        n_live++;
                    end
                end
                g = (n_live > 0 && $urandom_range(0, 99) < 85)
                    ? live_gens[$urandom_range(0, n_live - 1)] : $urandom;
                issue_request(MODE_ACK, wide[TIME_BITS-1:0], 3'($urandom), 1'($urandom),
                              $urandom, g);
            end else if (sel < 92) begin
                issue_request(MODE_TICK, clock_ms, 3'($urandom), 1'($urandom), $urandom,
                              $urandom);
            end else begin
                case ($urandom_range(0, 3))
                    0: issue_request(MODE_SPARE, wide[TIME_BITS-1:0], 3'($urandom),
                                     1'($urandom), $urandom, $urandom);
                    1: issue_request(MODE_ALLOC, '0, 3'($urandom), 1'($urandom), $urandom,
                                     $urandom);
                    2: issue_request(MODE_TICK, '0, 3'($urandom), 1'($urandom), $urandom,
                                     $urandom);
                    default: issue_request(MODE_ACK, wide[TIME_BITS-1:0], 3'($urandom),
                                           1'($urandom), $urandom, '0);
                endcase
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        aresetn          = 1'b0;
        cfg_valid        = 1'b0;
        cfg_ttl_ms       = '0;
        s_valid          = 1'b0;
        s_mode           = MODE_ALLOC;
        s_now_ms         = '0;
        s_queued_count   = '0;
        s_emergency      = 1'b0;
        s_event_tag      = '0;
        s_ack_generation = '0;
        m_ready          = 1'b0;
        calm             = 1'b0;
        error_count      = 0;
        items_sent       = 0;
        replies_checked  = 0;
        settings_used    = 0;
        quiet_cycles     = 0;
        last_gen         = '0;
        lifetime_ms      = TTL_RESET;
        clock_ms         = '0;
        for (int i = 0; i < SLOTS; i++) begin
            busy[i]      = 1'b0;
            deadline[i]  = '0;
            gen_of[i]    = '0;
            acks_left[i] = '0;
            urgent[i]    = 1'b0;
            tag_of[i]    = '0;
        end
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_invalid_items();
        test_allocate_and_ack();
        test_table_full();
        test_lifetime_extremes();
        clock_ms = 48'h0000_0100_0000;
        test_random_traffic(150, TTL_RESET, 64'd8000, 1'b1);
        test_random_traffic(150, 32'd1, 64'd2, 1'b0);
        test_random_traffic(120, TTL_BITS'($urandom_range(100, 5000)), 64'd1500, 1'b0);
        test_random_traffic(100, 32'hFFFF_FFFF, 64'd1 << 26, 1'b0);
        test_random_traffic(80, 32'd0, 64'd1, 1'b0);
        wait_tracker_idle();

        $display("Covered %0d requests and %0d replies over %0d lifetime settings,",
                 items_sent, replies_checked, settings_used);
        $display("including full table, saturated expiry and invalid requests; %0d mismatches",
                 error_count);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
